// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold whenever reset is released
`define CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lupp_pkg.sv =====
// ----------------------------------------------------------------------------
// lupp_pkg
// types, constants and arithmetic helpers for the lu factorization block
// ----------------------------------------------------------------------------
package lupp_pkg;
    localparam int MaxDim   = 8;
    localparam int FracBits = 16;
    localparam int IdxW     = 3;
    localparam int CntW     = 7;

    localparam logic [0:0] RegSize = 1'b0;
    localparam logic [0:0] RegThr  = 1'b1;

    typedef logic signed [31:0] t_word;

    typedef enum logic [3:0] {
        S_LOAD, S_PSCAN, S_SWAP, S_DIVSTART, S_DIVWAIT, S_MUL1, S_MUL2, S_MUL3,
        S_EMIT
    } t_state;

    // row cell control
    typedef struct packed {
        logic       wr;
        logic [2:0] col;
        t_word      data;
    } t_cell_wr;

    function automatic t_word sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// ===== hdl/lu_decomposition_partial_pivot.sv =====
// ----------------------------------------------------------------------------
// lu_decomposition_partial_pivot
// lu factorization with partial pivoting on a row chain of up to 8 x 8 words
// ----------------------------------------------------------------------------
// channel   | direction | handshake                 | payload
// input     | in        | i_start / o_busy          | i_element_value
// result    | out       | o_result_valid            | value, row, column, last
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// elements load row by row; the last element starts the run
// per column, a pivot scan over rows k..n-1 and a row swap; unless the pivot
// magnitude is at or below the threshold, each lower row then runs its divide,
// then its remaining columns through one multiplier unless its multiplier is 0
// results leave one per cycle, n*n words; busy rises the cycle after the last
// element; reset clears control state and returns the row map to identity
// results cannot be stalled
`include "assert_macros.svh"
module lu_decomposition_partial_pivot (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  lupp_pkg::t_word         i_element_value,
    output logic                    o_result_valid,
    output lupp_pkg::t_word         o_result_value,
    output logic [2:0]              o_row_index,
    output logic [2:0]              o_column_index,
    output logic                    o_last_of_run,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [30:0]             i_cfg_data
);
    import lupp_pkg::*;

    t_state      r_state, n_state;
    logic [3:0]  r_size;
    logic [30:0] r_thr;
    logic [CntW-1:0] r_lcnt, n_lcnt;
    logic [2:0]  r_lr, n_lr, r_lc, n_lc;
    logic [2:0]  r_map [MaxDim];
    logic [2:0]  n_map [MaxDim];
    logic [2:0]  r_k, n_k, r_i, n_i, r_j, n_j, r_best, n_best;
    logic [31:0] r_bestabs, n_bestabs;
    t_word       r_piv, n_piv, r_m, n_m, r_a, n_a, r_b, n_b;
    logic signed [63:0] r_prod, n_prod;
    logic        r_ov, n_ov, r_ol, n_ol;
    t_word       r_ov_val;
    logic [2:0]  r_or, n_or, r_oc, n_oc;
    logic [3:0]  dim;
    logic        div_done;
    t_word       div_q;
    logic        r_go;

    // chain read port
    logic [2:0]  rd_row, rd_col;
    t_word       chain [MaxDim+1];
    t_cell_wr    cwr;
    logic [2:0]  wr_row;

    assign dim = (r_size == 4'd0) ? 4'd1 : (r_size > 4'(MaxDim)) ? 4'(MaxDim) : r_size;
    assign o_cfg_ready = 1'b1;
    assign o_busy = (r_state != S_LOAD);

    assign chain[0] = '0;
    for (genvar g = 0; g < MaxDim; g++) begin : g_row
        t_cell_wr w;
        assign w.wr   = cwr.wr && (wr_row == 3'(g));
        assign w.col  = cwr.col;
        assign w.data = cwr.data;
        lupp_row_cell u_cell (
            .i_clk(i_clk), .i_wr(w), .i_rd_col(rd_col), .i_chain(chain[g]),
            .i_sel(rd_row == 3'(g)), .o_chain(chain[g+1])
        );
    end
    t_word rd_data;
    assign rd_data = chain[MaxDim];

    lupp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_go), .i_num(r_a),
        .i_den(r_piv), .o_done(div_done), .o_quo(div_q)
    );

    logic [31:0] rd_abs;
    assign rd_abs = rd_data[31] ? 32'(-rd_data) : 32'(rd_data);
    logic signed [65:0] prod_sh, diff;
    assign prod_sh = 66'(r_prod >>> FracBits);
    assign diff = 66'(r_a) - 66'(sat32(prod_sh));

    always_comb begin
        n_state = r_state; n_lcnt = r_lcnt; n_lr = r_lr; n_lc = r_lc;
        n_map = r_map; n_k = r_k; n_i = r_i; n_j = r_j; n_best = r_best;
        n_bestabs = r_bestabs; n_piv = r_piv; n_m = r_m; n_a = r_a; n_b = r_b;
        n_prod = r_prod; n_ov = 1'b0; n_ol = 1'b0; n_or = r_or; n_oc = r_oc;
        rd_row = r_map[r_i]; rd_col = r_k;
        cwr = '0; wr_row = r_map[r_i];
        case (r_state)
            S_LOAD: begin
                wr_row = r_lr;
                if (i_start) begin
                    cwr.wr = 1'b1; cwr.col = r_lc; cwr.data = i_element_value;
                    n_lcnt = r_lcnt + 7'd1;
                    if (4'({1'b0, r_lc}) == dim - 4'd1) begin
                        n_lc = '0; n_lr = r_lr + 3'd1;
                    end else begin
                        n_lc = r_lc + 3'd1;
                    end
                    if (n_lcnt == 7'(dim) * 7'(dim)) begin
                        n_k = '0; n_i = '0; n_best = '0; n_bestabs = '0;
                        n_state = (dim == 4'd1) ? S_EMIT : S_PSCAN;
                        n_j = '0;
                    end
                end
            end
            S_PSCAN: begin
                // walk rows k..n-1 comparing column k magnitudes
                rd_row = r_map[r_i];
                if (r_i == r_k || rd_abs > r_bestabs) begin
                    n_best = r_i; n_bestabs = rd_abs;
                end
                if (4'({1'b0, r_i}) == dim - 4'd1) n_state = S_SWAP;
                else n_i = r_i + 3'd1;
            end
            S_SWAP: begin
                n_map[r_k] = r_map[r_best];
                n_map[r_best] = r_map[r_k];
                rd_row = r_map[r_best];
                n_piv = rd_data;
                n_i = r_k + 3'd1;
                if (r_bestabs <= {1'b0, r_thr}) begin
                    if (4'({1'b0, r_k}) + 4'd2 >= dim) begin
                        n_state = S_EMIT; n_i = '0; n_j = '0;
                    end else begin
                        n_k = r_k + 3'd1; n_i = r_k + 3'd1; n_state = S_PSCAN;
                    end
                end else n_state = S_DIVSTART;
            end
            S_DIVSTART: begin
                rd_row = r_map[r_i]; rd_col = r_k;
                n_a = rd_data;
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (div_done) begin
                    n_m = div_q;
                    cwr.wr = 1'b1; cwr.col = r_k; cwr.data = div_q;
                    n_j = r_k + 3'd1;
                    n_state = (div_q == '0) ? S_MUL3 : S_MUL1;
                end
            end
            S_MUL1: begin
                // fetch pivot row word; the target word is fetched in S_MUL2
                rd_row = r_map[r_k]; rd_col = r_j;
                n_b = rd_data;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                rd_row = r_map[r_i]; rd_col = r_j;
                n_a = rd_data;
                n_prod = 64'(r_m) * 64'(r_b);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                if (r_m != '0) begin
                    cwr.wr = 1'b1; cwr.col = r_j; cwr.data = sat32(diff);
                end
                if (r_m != '0 && 4'({1'b0, r_j}) != dim - 4'd1) begin
                    n_j = r_j + 3'd1; n_state = S_MUL1;
                end else if (4'({1'b0, r_i}) != dim - 4'd1) begin
                    n_i = r_i + 3'd1; n_state = S_DIVSTART;
                end else if (4'({1'b0, r_k}) + 4'd2 >= dim) begin
                    n_state = S_EMIT; n_i = '0; n_j = '0;
                end else begin
                    n_k = r_k + 3'd1; n_i = r_k + 3'd1; n_state = S_PSCAN;
                end
            end
            S_EMIT: begin
                rd_row = r_map[r_i]; rd_col = r_j;
                n_ov = 1'b1; n_or = r_i; n_oc = r_j;
                if (4'({1'b0, r_j}) == dim - 4'd1) begin
                    n_j = '0;
                    if (4'({1'b0, r_i}) == dim - 4'd1) begin
                        n_ol = 1'b1; n_state = S_LOAD;
                        n_lcnt = '0; n_lr = '0; n_lc = '0; n_k = '0; n_i = '0;
                        for (int m = 0; m < MaxDim; m++) n_map[m] = 3'(m);
                    end else n_i = r_i + 3'd1;
                end else n_j = r_j + 3'd1;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // divider launches the cycle after the numerator is latched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_go <= 1'b0;
        else r_go <= (r_state == S_DIVSTART);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_size <= 4'd8; r_thr <= '0; r_lcnt <= '0;
            r_lr <= '0; r_lc <= '0; r_k <= '0; r_i <= '0; r_j <= '0;
            r_ov <= 1'b0; r_ol <= 1'b0;
            for (int m = 0; m < MaxDim; m++) r_map[m] <= 3'(m);
        end else begin
            r_state <= n_state; r_lcnt <= n_lcnt; r_lr <= n_lr; r_lc <= n_lc;
            r_k <= n_k; r_i <= n_i; r_j <= n_j; r_ov <= n_ov; r_ol <= n_ol;
            r_map <= n_map;
            if (i_cfg_valid && i_cfg_index == RegSize) begin
                r_size <= i_cfg_data[3:0];
                r_lcnt <= '0; r_lr <= '0; r_lc <= '0;
            end
            if (i_cfg_valid && i_cfg_index == RegThr) r_thr <= i_cfg_data;
        end
        r_best <= n_best; r_bestabs <= n_bestabs; r_piv <= n_piv; r_m <= n_m;
        r_a <= n_a; r_b <= n_b; r_prod <= n_prod; r_or <= n_or; r_oc <= n_oc;
        r_ov_val <= rd_data;
    end

    assign o_result_valid = r_ov;
    assign o_result_value = r_ov_val;
    assign o_row_index    = r_or;
    assign o_column_index = r_oc;
    assign o_last_of_run  = r_ol;

    `CHK(a_last_has_valid, !r_ol || r_ov, "last flag without result")
    `CHK_NEXT(a_start_in_busy, r_state == S_EMIT && n_state == S_LOAD, !o_busy,
        "block not idle after run")
    `CHK(a_no_load_when_busy, !(o_result_valid && r_state == S_PSCAN), "result during scan")
endmodule

// ===== hdl/lupp_div.sv =====
// ----------------------------------------------------------------------------
// lupp_div
// restoring divider, one quotient bit per cycle, signed with saturation
// ----------------------------------------------------------------------------
module lupp_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  lupp_pkg::t_word i_num,
    input  lupp_pkg::t_word i_den,
    output logic            o_done,
    output lupp_pkg::t_word o_quo
);
    import lupp_pkg::*;

    localparam int NumW = 32 + FracBits;

    logic [NumW-1:0] r_num, n_num;
    logic [32:0]     r_rem, n_rem;
    logic [31:0]     r_den, n_den;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [33:0]     trial;
    logic signed [NumW+1:0] q_signed;
    logic [31:0]     a_abs, d_abs;

    assign a_abs = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign d_abs = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign trial = {r_rem, r_num[NumW-1]} - {2'b0, r_den};
    assign q_signed = r_neg ? -$signed({2'b0, r_num}) : $signed({2'b0, r_num});

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_done = 1'b0;
        if (i_go) begin
            n_num  = {a_abs, {FracBits{1'b0}}};
            n_rem  = '0;
            n_den  = d_abs;
            n_cnt  = 6'(NumW);
            n_busy = 1'b1;
            n_neg  = i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!trial[33]) begin
                n_rem = trial[32:0];
                n_num = {r_num[NumW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_num[NumW-1]};
                n_num = {r_num[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num; r_rem <= n_rem; r_den <= n_den;
        r_cnt <= n_cnt; r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = sat32(66'(q_signed));
endmodule

// ===== hdl/lupp_row_cell.sv =====
// ----------------------------------------------------------------------------
// lupp_row_cell
// one stored row of the matrix; hands its word at the read column down the chain
// ----------------------------------------------------------------------------
module lupp_row_cell (
    input  logic               i_clk,
    input  lupp_pkg::t_cell_wr i_wr,
    input  logic [2:0]         i_rd_col,
    input  lupp_pkg::t_word    i_chain,
    input  logic               i_sel,
    output lupp_pkg::t_word    o_chain
);
    import lupp_pkg::*;

    t_word r_row [MaxDim];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_row[i_wr.col] <= i_wr.data;
        end
    end

    // selected cell drives its word, others pass the neighbor's word
    assign o_chain = i_sel ? r_row[i_rd_col] : i_chain;
endmodule

// ===== tb/lu_decomposition_partial_pivot_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decomposition_partial_pivot_tb
// streams matrices into the lu block under random gaps and register settings,
// predicts the packed l/u words per matrix and checks every emitted word
// ----------------------------------------------------------------------------
module lu_decomposition_partial_pivot_tb;
    import lupp_pkg::*;

    localparam int IdleWait   = 40;
    localparam int CycleLimit = 2000000;
    localparam int ItemTarget = 160;

    typedef enum logic {OP_ELEM, OP_CFG} t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic [31:0] data;
        logic        idx;
    } t_op;

    typedef struct {
        t_word      value;
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
    } t_lu_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_word       i_element_value = '0;
    logic        o_result_valid;
    t_word       o_result_value;
    logic [2:0]  o_row_index;
    logic [2:0]  o_column_index;
    logic        o_last_of_run;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = RegSize;
    logic [30:0] i_cfg_data = '0;

    lu_decomposition_partial_pivot uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_op      pending_ops[$];
    t_lu_word expected_words[$];
    int       mismatches = 0;
    int       gap_left = 0;
    int       idle_cycles = 0;
    int       cycle_count = 0;

    // predictor state
    longint   lu_store[64];
    int       row_order[8];
    int       loaded;
    int       size_reg = 8;
    longint   thr_reg = 0;

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs_word(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int cell_at(int r, int c);
        return row_order[r] * MaxDim + c;
    endfunction

    function automatic void clear_matrix_run();
        loaded = 0;
        for (int i = 0; i < 8; i++) row_order[i] = i;
    endfunction

    function automatic void factor_matrix(int n);
        int     best;
        int     t;
        longint piv;
        longint m;
        for (int k = 0; k + 1 < n; k++) begin
            best = k;
            for (int j = k + 1; j < n; j++)
                if (abs_word(lu_store[cell_at(j, k)]) > abs_word(lu_store[cell_at(best, k)]))
                    best = j;
            t = row_order[best];
            row_order[best] = row_order[k];
            row_order[k] = t;
            piv = lu_store[cell_at(k, k)];
            if (abs_word(piv) > thr_reg) begin
                for (int i = k + 1; i < n; i++) begin
                    m = sat_word((lu_store[cell_at(i, k)] <<< FracBits) / piv);
                    lu_store[cell_at(i, k)] = m;
                    if (m != 0)
                        for (int j = k + 1; j < n; j++)
                            lu_store[cell_at(i, j)] = sat_word(lu_store[cell_at(i, j)]
                                - sat_word((m * lu_store[cell_at(k, j)]) >>> FracBits));
                end
            end
        end
    endfunction

    function automatic void predict_element(t_word v);
        int       n;
        t_lu_word w;
        n = size_reg < 1 ? 1 : (size_reg > MaxDim ? MaxDim : size_reg);
        if (loaded >= n * n) loaded = 0;
        lu_store[(loaded / n) * MaxDim + loaded % n] = longint'(v);
        loaded++;
        if (loaded < n * n) return;
        factor_matrix(n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                w.value = t_word'(lu_store[cell_at(r, c)]);
                w.row = r[2:0];
                w.col = c[2:0];
                w.last = (r == n - 1) && (c == n - 1);
                expected_words.push_back(w);
            end
        clear_matrix_run();
    endfunction

    function automatic void predict_cfg(logic idx, logic [30:0] data);
        if (idx == RegSize) begin
            size_reg = int'(data[3:0]);
            loaded = 0;
        end else begin
            thr_reg = longint'(data);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_start && !o_busy) predict_element(i_element_value);
            if (i_cfg_valid && o_cfg_ready) predict_cfg(i_cfg_index, i_cfg_data);
            if ((i_start && o_busy) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the word until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                i_start <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (pending_ops[0].kind == OP_ELEM) begin
                i_start <= 1'b1;
                i_cfg_valid <= 1'b0;
                i_element_value <= pending_ops[0].data;
                void'(pending_ops.pop_front());
                gap_left <= pick_gap();
            end else if (expected_words.size() == 0 && !o_busy && !i_start
                         && idle_cycles >= IdleWait) begin
                i_start <= 1'b0;
                i_cfg_valid <= 1'b1;
                i_cfg_index <= pending_ops[0].idx;
                i_cfg_data <= pending_ops[0].data[30:0];
                void'(pending_ops.pop_front());
                gap_left <= pick_gap();
            end else begin
                i_start <= 1'b0;
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_lu_word w;
        cycle_count <= cycle_count + 1;
        if (expected_words.size() != 0 || o_busy || i_start || o_result_valid || i_cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_result_valid) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %h row %0d col %0d last %b",
                             o_result_value, o_row_index, o_column_index, o_last_of_run);
            end else begin
                w = expected_words.pop_front();
                if (w.value !== o_result_value || w.row !== o_row_index
                    || w.col !== o_column_index || w.last !== o_last_of_run) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp %h r%0d c%0d l%b, got %h r%0d c%0d l%b",
                                 w.value, w.row, w.col, w.last, o_result_value,
                                 o_row_index, o_column_index, o_last_of_run);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    int item_count = 0;

    task automatic add_elem(logic [31:0] v);
        t_op op;
        op.kind = OP_ELEM;
        op.data = v;
        op.idx = RegSize;
        pending_ops.push_back(op);
        item_count++;
    endtask

    task automatic add_cfg(logic idx, logic [31:0] v);
        t_op op;
        op.kind = OP_CFG;
        op.data = v;
        op.idx = idx;
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] rand_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (r < 88) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'h0001_0000;
        endcase
    endfunction

    initial begin
        int n;
        int eff;
        clear_matrix_run();
        foreach (lu_store[i]) lu_store[i] = 0;

        // one by one matrices at the value extremes
        add_cfg(RegSize, 1);
        add_cfg(RegThr, 0);
        add_elem(32'h7fff_ffff);
        add_elem(32'h8000_0000);
        // all zero: pivot skipped even at threshold zero
        add_cfg(RegSize, 2);
        repeat (4) add_elem(32'h0);
        // equal magnitudes, first row keeps the pivot
        add_elem(32'h0001_0000); add_elem(32'h0002_0000);
        add_elem(32'hffff_0000); add_elem(32'h0000_0005);
        // full-scale words in both rows
        add_elem(32'h8000_0000); add_elem(32'h8000_0000);
        add_elem(32'h7fff_ffff); add_elem(32'h7fff_ffff);
        // max threshold skips everything, swap still happens
        add_cfg(RegThr, 32'h7fff_ffff);
        add_elem(32'h0000_0003); add_elem(32'h1234_5678);
        add_elem(32'hffff_fff0); add_elem(32'h0000_0001);
        // zero size acts as one
        add_cfg(RegThr, 0);
        add_cfg(RegSize, 0);
        add_elem(32'h5a5a_a5a5);
        // partial load discarded by a size write
        add_cfg(RegSize, 3);
        repeat (4) add_elem(32'h0003_0000);
        add_cfg(RegSize, 2);
        add_elem(32'h0000_8000); add_elem(32'hfffe_0000);
        add_elem(32'h0004_0000); add_elem(32'h0000_0001);

        while (item_count < ItemTarget) begin
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = $urandom_range(9, 15);
                2, 3: n = $urandom_range(5, 8);
                default: n = $urandom_range(1, 4);
            endcase
            eff = n < 1 ? 1 : (n > MaxDim ? MaxDim : n);
            // keep the total near the target at the end
            if (ItemTarget - item_count < 64 && eff > 4) begin
                n = $urandom_range(1, 4);
                eff = n;
            end
            add_cfg(RegSize, n);
            case ($urandom_range(0, 9))
                0: add_cfg(RegThr, 32'h7fff_ffff);
                1, 2: add_cfg(RegThr, $urandom_range(0, 32'h0002_0000));
                3: add_cfg(RegThr, $urandom() & 32'h7fff_ffff);
                default: add_cfg(RegThr, 0);
            endcase
            repeat ($urandom_range(1, eff > 4 ? 1 : 3))
                repeat (eff * eff) add_elem(rand_element());
            if ($urandom_range(0, 5) == 0 && eff > 1)
                repeat ($urandom_range(1, eff * eff - 1)) add_elem(rand_element());
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ops.size() != 0 || expected_words.size() != 0 || i_start
               || idle_cycles < IdleWait)
            @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
